// ===== rtl/fbcs_pkg.sv =====
package fbcs_pkg;

	localparam int unsigned MS_W     = 10;
	localparam int unsigned FLAGS_W  = 6;
	localparam int unsigned BLINKS_W = 3;
	localparam int unsigned CFG_IDX_W = 1;

	// phase durations in milliseconds
	localparam logic [MS_W-1:0] HEADER_ON_MS       = 10'd200;
	localparam logic [MS_W-1:0] HEADER_OFF_MS      = 10'd200;
	localparam logic [MS_W-1:0] DETAIL_ON_TIME     = 10'd200;
	localparam logic [MS_W-1:0] DETAIL_OFF_TIME    = 10'd500;
	localparam logic [MS_W-1:0] CLOCK_FAULT_OFF_MS = 10'd300;
	localparam logic [MS_W-1:0] GAP_MS             = 10'd1000;

	localparam logic [BLINKS_W-1:0] HEADER_BLINKS = 3'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FAULT_FLAGS      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INDICATOR_ACTIVE = 1'b1;

	// blink counts per fault
	localparam logic [BLINKS_W-1:0] N_CURRENT  = 3'd2;
	localparam logic [BLINKS_W-1:0] N_CLOCK    = 3'd6;
	localparam logic [BLINKS_W-1:0] N_IMU_BARO = 3'd5;
	localparam logic [BLINKS_W-1:0] N_IMU      = 3'd3;
	localparam logic [BLINKS_W-1:0] N_BARO     = 3'd4;
	localparam logic [BLINKS_W-1:0] N_DRIFT    = 3'd7;
	localparam logic [BLINKS_W-1:0] N_NONE     = 3'd0;

	typedef struct packed {
		logic                red_led;
		logic                blue_led;
		logic [BLINKS_W-1:0] blue_blinks;
		logic                cycle_start;
	} fbcs_res_t;

	// priority pick of the blue blink count
	function automatic logic [BLINKS_W-1:0] pick_count(input logic [FLAGS_W-1:0] f);
		logic imu;
		logic baro;
		imu  = f[0] | f[1];
		baro = f[2];
		if (f[4])             pick_count = N_CURRENT;
		else if (f[5])        pick_count = N_CLOCK;
		else if (imu && baro) pick_count = N_IMU_BARO;
		else if (imu)         pick_count = N_IMU;
		else if (baro)        pick_count = N_BARO;
		else if (f[3])        pick_count = N_DRIFT;
		else                  pick_count = N_NONE;
	endfunction

	// short dark time only when the clock fault picked the count
	function automatic logic [MS_W-1:0] blue_off_ms(input logic [FLAGS_W-1:0] f);
		if (!f[4] && f[5]) blue_off_ms = CLOCK_FAULT_OFF_MS;
		else               blue_off_ms = DETAIL_OFF_TIME;
	endfunction

endpackage

// ===== rtl/fault_blink_code_sequencer_core.sv =====
// a result is registered in the main output register, or in the skid entry while the main register is held
// throughput: one tick transfer per cycle while the skid entry is free, set by the sequencer state update
// a two-entry output buffer (main plus skid) keeps tick_ready independent of out_ready
// reset (arst_n low, asynchronous): flags 0, indicator inactive, sequence at first
// red blink with 200 ms left, output buffer empty
module fault_blink_code_sequencer_core
	import fbcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FLAGS_W-1:0]   cfg_wdata,
	// tick input channel
	input  logic                 tick_valid,
	output logic                 tick_ready,
	input  logic                 tick,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 red_led,
	output logic                 blue_led,
	output logic [BLINKS_W-1:0]  blue_blinks,
	output logic                 cycle_start
);

	// configuration registers
	logic [FLAGS_W-1:0] fault_flags_q;
	logic               indicator_active_q;

	// output buffer
	fbcs_res_t res_comb;
	fbcs_res_t out_res_q;
	fbcs_res_t skid_res_q;
	logic      out_valid_q;
	logic      skid_valid_q;

	logic push;
	logic pop;

	// input transfer and output transfer
	assign push = tick_valid && tick_ready;
	assign pop  = out_valid_q && out_ready;

	// room as long as the skid entry is free
	assign tick_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_flags_q      <= '0;
			indicator_active_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FAULT_FLAGS:      fault_flags_q      <= cfg_wdata;
				REG_INDICATOR_ACTIVE: indicator_active_q <= cfg_wdata[0];
				default:              ;
			endcase
		end
	end

	// sequencer state is updated on each tick transfer, result computed in the same cycle
	fbcs_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (push),
		.tick             (tick),
		.fault_flags      (fault_flags_q),
		.indicator_active (indicator_active_q),
		.res              (res_comb)
	);

	// main output register: refilled from skid first, then from a fresh transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q <= skid_valid_q || push;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_res_q <= skid_res_q;
			end else if (push) begin
				out_res_q <= res_comb;
			end
		end
	end

	// skid entry catches a result while the main register is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			skid_valid_q <= !pop;
		end else if (push && out_valid_q && !pop) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q && push && out_valid_q && !pop) begin
			skid_res_q <= res_comb;
		end
	end

	assign out_valid   = out_valid_q;
	assign red_led     = out_res_q.red_led;
	assign blue_led    = out_res_q.blue_led;
	assign blue_blinks = out_res_q.blue_blinks;
	assign cycle_start = out_res_q.cycle_start;

`ifndef SYNTHESIS
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with main register empty");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q && !pop) |=> skid_valid_q)
		else $error("result lost while output stalled");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid_q)
		else $error("accepted tick produced no result");

	a_start_is_red: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_res_q.cycle_start) |-> out_res_q.red_led)
		else $error("cycle start without red led");
`endif

endmodule

// ===== rtl/fbcs_seq.sv =====
module fbcs_seq
	import fbcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               tick,
	input  logic [FLAGS_W-1:0] fault_flags,
	input  logic               indicator_active,
	output fbcs_res_t          res
);

	typedef enum logic [2:0] {
		PH_HDR_ON  = 3'd0,
		PH_HDR_OFF = 3'd1,
		PH_DET_ON  = 3'd2,
		PH_DET_OFF = 3'd3,
		PH_GAP     = 3'd4
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [MS_W-1:0]     ms_left_q, ms_left_d;
	logic [BLINKS_W-1:0] blinks_left_q, blinks_left_d;
	logic [BLINKS_W-1:0] n_pick;

	assign n_pick = pick_count(fault_flags);

	always_comb begin
		phase_d       = phase_q;
		ms_left_d     = ms_left_q;
		blinks_left_d = blinks_left_q;
		res.red_led     = 1'b0;
		res.blue_led    = 1'b0;
		res.blue_blinks = n_pick;
		res.cycle_start = 1'b0;
		if (!indicator_active) begin
			phase_d       = PH_HDR_ON;
			ms_left_d     = HEADER_ON_MS;
			blinks_left_d = HEADER_BLINKS;
		end else begin
			res.red_led  = (phase_q == PH_HDR_ON);
			res.blue_led = (phase_q == PH_DET_ON);
			if (tick) begin
				res.cycle_start = (phase_q == PH_HDR_ON) && (blinks_left_q == HEADER_BLINKS)
					&& (ms_left_q == HEADER_ON_MS);
				if (ms_left_q <= MS_W'(1)) begin
					case (phase_q)
						PH_HDR_ON: begin
							phase_d   = PH_HDR_OFF;
							ms_left_d = HEADER_OFF_MS;
						end
						PH_HDR_OFF: begin
							if (blinks_left_q > BLINKS_W'(1)) begin
								blinks_left_d = blinks_left_q - BLINKS_W'(1);
								phase_d       = PH_HDR_ON;
								ms_left_d     = HEADER_ON_MS;
							end else if (n_pick != N_NONE) begin
								phase_d       = PH_DET_ON;
								blinks_left_d = n_pick;
								ms_left_d     = DETAIL_ON_TIME;
							end else begin
								phase_d       = PH_GAP;
								blinks_left_d = '0;
								ms_left_d     = GAP_MS;
							end
						end
						PH_DET_ON: begin
							phase_d   = PH_DET_OFF;
							ms_left_d = blue_off_ms(fault_flags);
						end
						PH_DET_OFF: begin
							if (blinks_left_q > BLINKS_W'(1)) begin
								blinks_left_d = blinks_left_q - BLINKS_W'(1);
								phase_d       = PH_DET_ON;
								ms_left_d     = DETAIL_ON_TIME;
							end else begin
								phase_d       = PH_GAP;
								blinks_left_d = '0;
								ms_left_d     = GAP_MS;
							end
						end
						default: begin
							// end of gap, or a meaningless code: restart the cycle
							phase_d       = PH_HDR_ON;
							ms_left_d     = HEADER_ON_MS;
							blinks_left_d = HEADER_BLINKS;
						end
					endcase
				end else begin
					ms_left_d = ms_left_q - MS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HDR_ON;
			ms_left_q     <= HEADER_ON_MS;
			blinks_left_q <= HEADER_BLINKS;
		end else if (step) begin
			phase_q       <= phase_d;
			ms_left_q     <= ms_left_d;
			blinks_left_q <= blinks_left_d;
		end
	end

`ifndef SYNTHESIS
	a_gap_no_blinks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_GAP |-> blinks_left_q == '0)
		else $error("blink count left nonzero in gap");

	a_header_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HDR_ON || phase_q == PH_HDR_OFF)
		|-> (blinks_left_q == BLINKS_W'(1) || blinks_left_q == HEADER_BLINKS))
		else $error("header blink count out of range");

	a_inactive_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !indicator_active) |=> (phase_q == PH_HDR_ON
		&& ms_left_q == HEADER_ON_MS && blinks_left_q == HEADER_BLINKS))
		else $error("inactive step did not restart sequence");
`endif

endmodule

// ===== test/fbcs_led_checker.sv =====
module fbcs_led_checker
	import fbcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FLAGS_W-1:0]   cfg_wdata,
	input  logic                 tick_valid,
	input  logic                 tick_ready,
	input  logic                 tick,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 red_led,
	input  logic                 blue_led,
	input  logic [BLINKS_W-1:0]  blue_blinks,
	input  logic                 cycle_start,
	output int                   mismatches,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// fault flag bit positions
	localparam int FLAG_ACC_MISSING = 0;
	localparam int FLAG_ACC_INCOMPAT = 1;
	localparam int FLAG_BARO = 2;
	localparam int FLAG_BARO_DRIFT = 3;
	localparam int FLAG_CURRENT = 4;
	localparam int FLAG_CLOCK = 5;

	typedef enum logic [2:0] {
		RED_ON,
		RED_OFF,
		BLUE_ON,
		BLUE_OFF,
		DARK_GAP
	} blink_phase_t;

	blink_phase_t        phase;
	logic [MS_W-1:0]     ms_left;
	logic [BLINKS_W-1:0] blinks_left;
	logic [FLAGS_W-1:0]  flags;
	logic                active;

	fbcs_res_t led_q[$];
	fbcs_res_t want;
	int        errs = 0;

	function automatic logic [BLINKS_W-1:0] fault_blink_count(input logic [FLAGS_W-1:0] f);
		logic imu_fault;
		imu_fault = f[FLAG_ACC_MISSING] | f[FLAG_ACC_INCOMPAT];
		if (f[FLAG_CURRENT])
			return N_CURRENT;
		if (f[FLAG_CLOCK])
			return N_CLOCK;
		if (imu_fault && f[FLAG_BARO])
			return N_IMU_BARO;
		if (imu_fault)
			return N_IMU;
		if (f[FLAG_BARO])
			return N_BARO;
		if (f[FLAG_BARO_DRIFT])
			return N_DRIFT;
		return N_NONE;
	endfunction

	// clock fault shortens the dark part only when it set the count
	function automatic logic [MS_W-1:0] blue_dark_ms(input logic [FLAGS_W-1:0] f);
		return (f[FLAG_CLOCK] && !f[FLAG_CURRENT]) ? CLOCK_FAULT_OFF_MS : DETAIL_OFF_TIME;
	endfunction

	task automatic restart_sequence();
		phase = RED_ON;
		ms_left = HEADER_ON_MS;
		blinks_left = HEADER_BLINKS;
	endtask

	task automatic enter_gap();
		phase = DARK_GAP;
		blinks_left = '0;
		ms_left = GAP_MS;
	endtask

	task automatic end_of_phase();
		logic [BLINKS_W-1:0] n;
		case (phase)
			RED_ON: begin
				phase = RED_OFF;
				ms_left = HEADER_OFF_MS;
			end
			RED_OFF: begin
				if (blinks_left > 1) begin
					blinks_left = blinks_left - 1'b1;
					phase = RED_ON;
					ms_left = HEADER_ON_MS;
				end else begin
					n = fault_blink_count(flags);
					if (n != N_NONE) begin
						phase = BLUE_ON;
						blinks_left = n;
						ms_left = DETAIL_ON_TIME;
					end else begin
						enter_gap();
					end
				end
			end
			BLUE_ON: begin
				phase = BLUE_OFF;
				ms_left = blue_dark_ms(flags);
			end
			BLUE_OFF: begin
				if (blinks_left > 1) begin
					blinks_left = blinks_left - 1'b1;
					phase = BLUE_ON;
					ms_left = DETAIL_ON_TIME;
				end else begin
					enter_gap();
				end
			end
			default: begin
				restart_sequence();
			end
		endcase
	endtask

	// led levels for this millisecond, then advance the sequence
	task automatic advance_one(input logic t, output fbcs_res_t r);
		r = '0;
		r.blue_blinks = fault_blink_count(flags);
		if (!active) begin
			restart_sequence();
		end else begin
			r.red_led = (phase == RED_ON);
			r.blue_led = (phase == BLUE_ON);
			if (t) begin
				r.cycle_start = (phase == RED_ON) && (blinks_left == HEADER_BLINKS) &&
					(ms_left == HEADER_ON_MS);
				if (ms_left <= 1)
					end_of_phase();
				else
					ms_left = ms_left - 1'b1;
			end
		end
	endtask

	task automatic report(input string msg);
		errs++;
		$display("%0t ns led mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags = '0;
			active = 1'b0;
			restart_sequence();
			led_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FAULT_FLAGS)
					flags = cfg_wdata;
				else if (cfg_index == REG_INDICATOR_ACTIVE)
					active = cfg_wdata[0];
			end
			if (out_valid && out_ready) begin
				if (led_q.size() == 0) begin
					report("result transfer with no tick waiting");
				end else begin
					want = led_q.pop_front();
					if (red_led !== want.red_led)
						report($sformatf("red_led got %b want %b", red_led, want.red_led));
					if (blue_led !== want.blue_led)
						report($sformatf("blue_led got %b want %b", blue_led, want.blue_led));
					if (blue_blinks !== want.blue_blinks)
						report($sformatf("blue_blinks got %0d want %0d",
							blue_blinks, want.blue_blinks));
					if (cycle_start !== want.cycle_start)
						report($sformatf("cycle_start got %b want %b",
							cycle_start, want.cycle_start));
				end
			end
			if (tick_valid && tick_ready) begin
				advance_one(tick, want);
				led_q.push_back(want);
			end
		end
		outstanding <= led_q.size();
		mismatches <= errs;
	end

endmodule

// ===== test/tb_fault_blink_code_sequencer_core.sv =====
module tb_fault_blink_code_sequencer_core;
	import fbcs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// stimulus shape
	localparam int SEGMENTS    = 24;
	localparam int HOLD_SEG    = 2;    // segment where the sink holds off for a long stretch
	localparam int PAUSE_SEG   = 5;    // segment where the source waits for all results mid-run
	localparam int HOLD_CYCLES = 48;
	localparam int SETTLE      = 4;
	localparam int STALL_LIMIT = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FLAGS_W-1:0]   cfg_wdata;
	logic                 tick_valid;
	logic                 tick_ready;
	logic                 tick;
	logic                 out_valid;
	logic                 out_ready;
	logic                 red_led;
	logic                 blue_led;
	logic [BLINKS_W-1:0]  blue_blinks;
	logic                 cycle_start;

	int fail_count;
	int outstanding;
	int quiet_cycles = 0;
	int holds_asked;
	bit idle_on;

	fault_blink_code_sequencer_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.tick       (tick),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red_led    (red_led),
		.blue_led   (blue_led),
		.blue_blinks(blue_blinks),
		.cycle_start(cycle_start)
	);

	fbcs_led_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.tick       (tick),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red_led    (red_led),
		.blue_led   (blue_led),
		.blue_blinks(blue_blinks),
		.cycle_start(cycle_start),
		.mismatches (fail_count),
		.outstanding(outstanding)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog: any transfer or register write counts as progress
	always @(posedge clk) begin
		if ((tick_valid && tick_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("fault_blink_code_sequencer_core regression: fail");
			$finish;
		end
	end

	// register write, one cycle pulse, only while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FLAGS_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// offer one tick and hold it until the transfer; ready is sampled mid-cycle
	// so the decision never races the edge
	task automatic send_tick(input logic t);
		logic took;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		tick_valid <= 1'b1;
		tick <= t;
		do begin
			@(negedge clk);
			took = tick_ready;
			@(posedge clk);
		end while (!took);
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic wait_drained();
		tick_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// result sink: random ready bursts, plus one long hold-off on request
	initial begin : sink
		int served;
		served = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_asked != served) begin
				served++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [FLAGS_W-1:0] f;
		logic               on;
		int                 len;
		int                 seg;
		int                 k;
		logic [FLAGS_W-1:0] corner_flags[10];

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		tick_valid = 1'b0;
		tick = 1'b0;
		idle_on = 1'b0;
		holds_asked = 0;
		corner_flags = '{6'h00, 6'h01, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20, 6'h3F, 6'h05, 6'h28};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// inactive after reset: dark leds, count from reset flags
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		wait_drained();
		write_reg(REG_FAULT_FLAGS, '1);
		send_tick(1'b1);
		wait_drained();

		// active: first tick opens a cycle, then every fault priority
		write_reg(REG_INDICATOR_ACTIVE, FLAGS_W'(1'b1));
		foreach (corner_flags[i]) begin
			write_reg(REG_FAULT_FLAGS, corner_flags[i]);
			send_tick(i[0] == 1'b0);
			wait_drained();
		end
		write_reg(REG_INDICATOR_ACTIVE, FLAGS_W'(1'b0));
		send_tick(1'b1);
		wait_drained();

		// tick runs; the sequence carries across segments while active,
		// so new flags land mid-cycle and longer active stretches reach the blue part
		for (seg = 0; seg < SEGMENTS; seg++) begin
			idle_on = (seg < SEGMENTS - 2) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 3))
				0: f = '0;
				1: begin
					f = '0;
					f[$urandom_range(0, FLAGS_W - 1)] = 1'b1;
				end
				2: f = '1;
				default: f = FLAGS_W'($urandom_range(0, 63));
			endcase
			on = (seg == HOLD_SEG) || ($urandom_range(0, 7) != 0);
			write_reg(REG_FAULT_FLAGS, f);
			write_reg(REG_INDICATOR_ACTIVE, FLAGS_W'(on));
			len = on ? $urandom_range(25, 60) : $urandom_range(5, 15);
			for (k = 0; k < len; k++) begin
				// sink stalls while ticks keep coming so the buffer fills up
				if (seg == HOLD_SEG && k == 10)
					holds_asked++;
				if (seg == PAUSE_SEG && k == len / 2)
					wait_drained();
				send_tick($urandom_range(0, 15) != 0);
			end
			wait_drained();
		end

		if (fail_count == 0)
			$display("fault_blink_code_sequencer_core regression: pass");
		else
			$display("fault_blink_code_sequencer_core regression: fail");
		$finish;
	end

endmodule
